@@ rtl/tap_pkg.sv @@
package tap_pkg;

    localparam int SIZE_BITS = 13;
    localparam int IDX_BITS  = 12;
    localparam int WH_BITS   = 2 * SIZE_BITS;
    localparam int TOT_BITS  = 3 * SIZE_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_EARLY = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_W = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_H = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_C = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERM   = 3'd3;

    localparam logic [2:0] PERM_CHW = 3'd0;
    localparam logic [2:0] PERM_CWH = 3'd1;
    localparam logic [2:0] PERM_HCW = 3'd2;
    localparam logic [2:0] PERM_HWC = 3'd3;
    localparam logic [2:0] PERM_WCH = 3'd4;
    localparam logic [2:0] PERM_WHC = 3'd5;

    typedef enum logic [1:0] {
        AX_W,
        AX_H,
        AX_C
    } t_axis;

    typedef struct packed {
        t_axis outer;
        t_axis mid;
        t_axis inner;
    } t_levels;

    typedef enum logic [1:0] {
        CS_READY,
        CS_MUL1,
        CS_MUL2
    } t_cfg_state;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

    function automatic t_levels perm_levels(input logic [2:0] code);
        t_levels lv;
        case (code)
            PERM_CWH: lv = '{outer: AX_C, mid: AX_W, inner: AX_H};
            PERM_HCW: lv = '{outer: AX_H, mid: AX_C, inner: AX_W};
            PERM_HWC: lv = '{outer: AX_H, mid: AX_W, inner: AX_C};
            PERM_WCH: lv = '{outer: AX_W, mid: AX_C, inner: AX_H};
            PERM_WHC: lv = '{outer: AX_W, mid: AX_H, inner: AX_C};
            default:  lv = '{outer: AX_C, mid: AX_H, inner: AX_W};
        endcase
        return lv;
    endfunction

endpackage

@@ rtl/tensor_axis_permute_3d.sv @@
// Each item's result shows on o_done in the cycle after it is accepted;
// results cannot be stalled. One item per cycle while busy is low; an
// item reads or writes the store at most once. Sizes feed a two-stage
// multiply after reset and each size or perm write; busy is high in both.
// Reset (i_rst_n low at a clock edge) restores sizes 1x1x1, perm chw and
// clears the load count and fetch counters; store contents are not cleared.
module tensor_axis_permute_3d #(
    parameter int MAX_ELEMS = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_op,
    input  logic [WORD_BITS-1:0]             i_word_in,
    output logic                             o_done,
    output logic [WORD_BITS-1:0]             o_word_out,
    output logic                             o_last,
    output logic [1:0]                       o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tap_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [tap_pkg::SIZE_BITS-1:0]    i_cfg_data
);
    import tap_pkg::*;

    localparam int AW = $clog2(MAX_ELEMS);

    t_mem_ctl       mem_ctl;
    logic [AW-1:0]  mem_addr;
    logic [WORD_BITS-1:0] rdata;

    tap_store #(
        .DEPTH (MAX_ELEMS),
        .AW    (AW),
        .WB    (WORD_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (i_word_in),
        .o_rdata (rdata)
    );

    tap_ctrl #(
        .MAX_ELEMS (MAX_ELEMS),
        .AW        (AW),
        .WB        (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_op        (i_op),
        .o_busy      (o_busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rdata     (rdata),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_done      (o_done),
        .o_word_out  (o_word_out),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule

@@ rtl/tap_store.sv @@
module tap_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int WB    = 32
) (
    input  logic              i_clk,
    input  tap_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [WB-1:0]     i_wdata,
    output logic [WB-1:0]     o_rdata
);
    import tap_pkg::*;

    logic [WB-1:0] r_mem [DEPTH];
    logic [WB-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tap_ctrl.sv @@
module tap_ctrl #(
    parameter int MAX_ELEMS = 4096,
    parameter int AW        = 12,
    parameter int WB        = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_op,
    output logic                               o_busy,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tap_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tap_pkg::SIZE_BITS-1:0]      i_cfg_data,
    input  logic [WB-1:0]                      i_rdata,
    output tap_pkg::t_mem_ctl                  o_mem_ctl,
    output logic [AW-1:0]                      o_mem_addr,
    output logic                               o_done,
    output logic [WB-1:0]                      o_word_out,
    output logic                               o_last,
    output logic [1:0]                         o_status
);
    import tap_pkg::*;

    localparam int CW = $clog2(MAX_ELEMS + 1);

    t_cfg_state r_state, n_state;
    logic mul1_en, mul2_en;

    logic [SIZE_BITS-1:0] r_size_w, r_size_h, r_size_c;
    logic [2:0]           r_perm;
    logic [WH_BITS-1:0]   r_wh;
    logic [TOT_BITS-1:0]  r_total;
    logic [SIZE_BITS-1:0] r_n_out, r_n_mid, r_n_in;
    logic [AW-1:0]        r_s_out, r_s_mid, r_s_in;

    logic [CW-1:0]       r_load_cnt, n_load_cnt;
    logic [IDX_BITS-1:0] r_idx_out, n_idx_out, r_idx_mid, n_idx_mid, r_idx_in, n_idx_in;
    logic [AW-1:0]       r_out_base, n_out_base, r_mid_base, n_mid_base, r_addr, n_addr;

    logic       r_done, r_fetch, n_fetch, r_last, n_last;
    logic [1:0] r_status, n_status;

    logic     accept, cfg_wr, cfg_hit, bad, load_full;
    logic     in_end, mid_end, out_end;
    t_levels  lv;
    t_mem_ctl mem_ctl;
    logic [AW-1:0]        mem_addr, step_mid, step_out;
    logic [SIZE_BITS-1:0] lv_n_out, lv_n_mid, lv_n_in;
    logic [AW-1:0]        lv_s_out, lv_s_mid, lv_s_in;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign cfg_hit = cfg_wr && (i_cfg_index <= REG_PERM);
    assign accept  = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_READY: n_state = CS_READY;
            CS_MUL1:  n_state = CS_MUL2;
            CS_MUL2:  n_state = CS_READY;
            default:  n_state = CS_MUL1;
        endcase
        if (cfg_hit) begin
            n_state = CS_MUL1;
        end
    end

    always_comb begin
        o_busy  = 1'b1;
        mul1_en = 1'b0;
        mul2_en = 1'b0;
        unique case (r_state)
            CS_READY: o_busy  = 1'b0;
            CS_MUL1:  mul1_en = 1'b1;
            CS_MUL2:  mul2_en = 1'b1;
            default:  o_busy  = 1'b1;
        endcase
    end

    function automatic logic [SIZE_BITS-1:0] size_of(
        input t_axis ax,
        input logic [SIZE_BITS-1:0] w, h, c
    );
        logic [SIZE_BITS-1:0] s;
        case (ax)
            AX_W:    s = w;
            AX_H:    s = h;
            default: s = c;
        endcase
        return s;
    endfunction

    function automatic logic [AW-1:0] stride_of(
        input t_axis ax,
        input logic [SIZE_BITS-1:0] w,
        input logic [WH_BITS-1:0] wh
    );
        logic [AW-1:0] s;
        case (ax)
            AX_W:    s = AW'(1);
            AX_H:    s = AW'(w);
            default: s = AW'(wh);
        endcase
        return s;
    endfunction

    always_comb begin
        lv       = perm_levels(r_perm);
        lv_n_out = size_of(lv.outer, r_size_w, r_size_h, r_size_c);
        lv_n_mid = size_of(lv.mid, r_size_w, r_size_h, r_size_c);
        lv_n_in  = size_of(lv.inner, r_size_w, r_size_h, r_size_c);
        lv_s_out = stride_of(lv.outer, r_size_w, r_wh);
        lv_s_mid = stride_of(lv.mid, r_size_w, r_wh);
        lv_s_in  = stride_of(lv.inner, r_size_w, r_wh);
    end

    assign bad       = (r_total == '0) || (r_total > TOT_BITS'(MAX_ELEMS));
    assign load_full = TOT_BITS'(r_load_cnt) >= r_total;
    assign in_end    = ({1'b0, r_idx_in} + 1'b1) == r_n_in;
    assign mid_end   = ({1'b0, r_idx_mid} + 1'b1) == r_n_mid;
    assign out_end   = ({1'b0, r_idx_out} + 1'b1) == r_n_out;
    assign step_mid  = r_mid_base + r_s_mid;
    assign step_out  = r_out_base + r_s_out;

    always_comb begin
        n_load_cnt = r_load_cnt;
        n_idx_out  = r_idx_out;
        n_idx_mid  = r_idx_mid;
        n_idx_in   = r_idx_in;
        n_out_base = r_out_base;
        n_mid_base = r_mid_base;
        n_addr     = r_addr;
        mem_ctl    = '0;
        mem_addr   = r_addr;
        n_fetch    = 1'b0;
        n_last     = 1'b0;
        n_status   = ST_OK;
        if (accept) begin
            if (bad) begin
                n_status = ST_BAD;
            end else if (i_op == OP_LOAD) begin
                if (load_full) begin
                    n_status = ST_BAD;
                end else begin
                    mem_ctl.wr = 1'b1;
                    mem_addr   = r_load_cnt[AW-1:0];
                    n_load_cnt = r_load_cnt + 1'b1;
                end
            end else if (!load_full) begin
                n_status = ST_EARLY;
            end else begin
                mem_ctl.rd = 1'b1;
                n_fetch    = 1'b1;
                if (!in_end) begin
                    n_idx_in = r_idx_in + 1'b1;
                    n_addr   = r_addr + r_s_in;
                end else if (!mid_end) begin
                    n_idx_in   = '0;
                    n_idx_mid  = r_idx_mid + 1'b1;
                    n_mid_base = step_mid;
                    n_addr     = step_mid;
                end else if (!out_end) begin
                    n_idx_in   = '0;
                    n_idx_mid  = '0;
                    n_idx_out  = r_idx_out + 1'b1;
                    n_out_base = step_out;
                    n_mid_base = step_out;
                    n_addr     = step_out;
                end else begin
                    // final word: ready for the next tensor
                    n_last     = 1'b1;
                    n_load_cnt = '0;
                    n_idx_in   = '0;
                    n_idx_mid  = '0;
                    n_idx_out  = '0;
                    n_out_base = '0;
                    n_mid_base = '0;
                    n_addr     = '0;
                end
            end
        end
        if (cfg_hit) begin
            n_load_cnt = '0;
            n_idx_in   = '0;
            n_idx_mid  = '0;
            n_idx_out  = '0;
            n_out_base = '0;
            n_mid_base = '0;
            n_addr     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CS_MUL1;
            r_size_w   <= SIZE_BITS'(1);
            r_size_h   <= SIZE_BITS'(1);
            r_size_c   <= SIZE_BITS'(1);
            r_perm     <= PERM_CHW;
            r_load_cnt <= '0;
            r_idx_out  <= '0;
            r_idx_mid  <= '0;
            r_idx_in   <= '0;
            r_out_base <= '0;
            r_mid_base <= '0;
            r_addr     <= '0;
            r_done     <= 1'b0;
            r_fetch    <= 1'b0;
            r_last     <= 1'b0;
            r_status   <= ST_OK;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_idx_out  <= n_idx_out;
            r_idx_mid  <= n_idx_mid;
            r_idx_in   <= n_idx_in;
            r_out_base <= n_out_base;
            r_mid_base <= n_mid_base;
            r_addr     <= n_addr;
            r_done     <= accept;
            r_fetch    <= n_fetch;
            r_last     <= n_last;
            r_status   <= n_status;
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_SIZE_W: r_size_w <= i_cfg_data;
                    REG_SIZE_H: r_size_h <= i_cfg_data;
                    REG_SIZE_C: r_size_c <= i_cfg_data;
                    REG_PERM:   r_perm   <= i_cfg_data[2:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul1_en) begin
            r_wh <= r_size_w * r_size_h;
        end
        if (mul2_en) begin
            r_total <= r_wh * r_size_c;
            r_n_out <= lv_n_out;
            r_n_mid <= lv_n_mid;
            r_n_in  <= lv_n_in;
            r_s_out <= lv_s_out;
            r_s_mid <= lv_s_mid;
            r_s_in  <= lv_s_in;
        end
    end

    assign o_mem_ctl  = mem_ctl;
    assign o_mem_addr = mem_addr;
    assign o_done     = r_done;
    assign o_word_out = r_fetch ? i_rdata : '0;
    assign o_last     = r_last;
    assign o_status   = r_status;

endmodule

@@ rtl/tap_check.sv @@
module tap_check #(
    parameter int WORD_BITS = 32
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic                             o_done,
    input logic [WORD_BITS-1:0]             o_word_out,
    input logic                             o_last,
    input logic [1:0]                       o_status,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [tap_pkg::CFG_IDX_BITS-1:0] i_cfg_index
);
    import tap_pkg::*;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("accepted item gave no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("result without an accepted item");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_done && o_status == ST_OK))
        else $error("last flag on a failed or missing result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_word_out == '0 && !o_last))
        else $error("error result carries data");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_PERM) |=> o_busy)
        else $error("register write did not hold off items");

endmodule

bind tensor_axis_permute_3d tap_check #(
    .WORD_BITS (WORD_BITS)
) u_tap_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_word_out  (o_word_out),
    .o_last      (o_last),
    .o_status    (o_status),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tap_pkg::*;

    localparam int MAX_ELEMS = 4096;
    localparam int WORD_BITS = 32;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1650;

    // register indexes and perm codes that the block leaves unused
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_FIRST = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LAST  = 3'd7;
    localparam logic [2:0] PERM_SPARE_A = 3'd6;
    localparam logic [2:0] PERM_SPARE_B = 3'd7;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic [1:0]           status;
    } t_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_BITS-1:0] cfg_index;
        logic [SIZE_BITS-1:0]  cfg_data;
        logic                  op;
        logic [WORD_BITS-1:0]  word;
        logic                  typed;
        t_result               want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic                      i_op;
    logic [WORD_BITS-1:0]      i_word_in;
    logic                      o_done;
    logic [WORD_BITS-1:0]      o_word_out;
    logic                      o_last;
    logic [1:0]                o_status;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [SIZE_BITS-1:0]      i_cfg_data;

    tensor_axis_permute_3d #(
        .MAX_ELEMS(MAX_ELEMS),
        .WORD_BITS(WORD_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_op       (i_op),
        .i_word_in  (i_word_in),
        .o_done     (o_done),
        .o_word_out (o_word_out),
        .o_last     (o_last),
        .o_status   (o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block: sizes, loop order, load progress and stored words
    logic [SIZE_BITS-1:0] dim_w = SIZE_BITS'(1);
    logic [SIZE_BITS-1:0] dim_h = SIZE_BITS'(1);
    logic [SIZE_BITS-1:0] dim_c = SIZE_BITS'(1);
    logic [2:0]           perm = PERM_CHW;
    int unsigned          loaded = 0;
    int unsigned          idx_outer = 0;
    int unsigned          idx_mid = 0;
    int unsigned          idx_inner = 0;
    logic [WORD_BITS-1:0] tensor_words [MAX_ELEMS];

    t_result     pending_results [$];
    logic        typed_on = 1'b0;
    t_result     typed_val;
    int unsigned n_items = 0;
    int unsigned n_cfg = 0;
    int unsigned n_fail = 0;
    int unsigned cycles = 0;

    function automatic void clear_progress();
        loaded = 0;
        idx_outer = 0;
        idx_mid = 0;
        idx_inner = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [SIZE_BITS-1:0] data);
        case (idx)
            REG_SIZE_W: dim_w = data;
            REG_SIZE_H: dim_h = data;
            REG_SIZE_C: dim_c = data;
            REG_PERM:   perm = data[2:0];
            default:    return;
        endcase
        clear_progress();
    endfunction

    function automatic int unsigned axis_len(input t_axis a);
        case (a)
            AX_W:    return dim_w;
            AX_H:    return dim_h;
            default: return dim_c;
        endcase
    endfunction

    function automatic t_result permute_step(input logic op, input logic [WORD_BITS-1:0] word);
        t_result         r;
        longint unsigned total;
        t_axis           ax_o;
        t_axis           ax_m;
        t_axis           ax_i;
        int unsigned     pos [3];
        int unsigned     addr;
        r.word = '0;
        r.last = 1'b0;
        r.status = ST_OK;
        total = dim_w;
        total = total * dim_h * dim_c;
        if (total == 0 || total > MAX_ELEMS) begin
            r.status = ST_BAD;
        end else if (op == OP_LOAD) begin
            if (loaded >= total) begin
                r.status = ST_BAD;
            end else begin
                tensor_words[loaded] = word;
                loaded++;
            end
        end else if (loaded < total) begin
            r.status = ST_EARLY;
        end else begin
            case (perm)
                PERM_CWH: begin ax_o = AX_C; ax_m = AX_W; ax_i = AX_H; end
                PERM_HCW: begin ax_o = AX_H; ax_m = AX_C; ax_i = AX_W; end
                PERM_HWC: begin ax_o = AX_H; ax_m = AX_W; ax_i = AX_C; end
                PERM_WCH: begin ax_o = AX_W; ax_m = AX_C; ax_i = AX_H; end
                PERM_WHC: begin ax_o = AX_W; ax_m = AX_H; ax_i = AX_C; end
                default:  begin ax_o = AX_C; ax_m = AX_H; ax_i = AX_W; end
            endcase
            pos[ax_o] = idx_outer;
            pos[ax_m] = idx_mid;
            pos[ax_i] = idx_inner;
            addr = (pos[AX_C] * dim_h + pos[AX_H]) * dim_w + pos[AX_W];
            r.word = tensor_words[addr];
            idx_inner++;
            if (idx_inner >= axis_len(ax_i)) begin
                idx_inner = 0;
                idx_mid++;
                if (idx_mid >= axis_len(ax_m)) begin
                    idx_mid = 0;
                    idx_outer++;
                    if (idx_outer >= axis_len(ax_o)) begin
                        r.last = 1'b1;
                        clear_progress();
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tensor_axis_permute_3d test failed");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(i_cfg_index, i_cfg_data);
                n_cfg++;
            end
            if (i_start && !o_busy) begin
                exp_r = permute_step(i_op, i_word_in);
                pending_results = {pending_results, (typed_on ? typed_val : exp_r)};
                n_items++;
            end
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item outstanding");
                    n_fail++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_word_out !== exp_r.word) begin
                        $error("word_out: expected %h, got %h", exp_r.word, o_word_out);
                        n_fail++;
                    end
                    if (o_last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, o_last);
                        n_fail++;
                    end
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_status);
                        n_fail++;
                    end
                end
            end
        end
    end

    function automatic bit steady();
        return n_items >= 500 && n_items < 900;
    endfunction

    task automatic idle_maybe();
        if (!steady() && $urandom_range(99) < 10) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic issue(input logic op, input logic [WORD_BITS-1:0] word);
        int unsigned seen;
        seen = n_items;
        i_start <= 1'b1;
        i_op <= op;
        i_word_in <= word;
        do @(negedge i_clk); while (n_items == seen);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] data);
        int unsigned seen;
        if (!steady() && $urandom_range(99) < 10)
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        seen = n_cfg;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (n_cfg == seen);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // one setting: program it, then load and fetch tensors with some noise
    task automatic tensor_pass(input logic [SIZE_BITS-1:0] w, h, c, input logic [2:0] pm);
        longint unsigned total;
        int unsigned     k;
        int unsigned     early_at;
        int unsigned     stop_at;
        int unsigned     rounds;
        logic [SIZE_BITS-1:0] perm_data;
        total = w;
        total = total * h * c;
        drain();
        if (w != dim_w || $urandom_range(1)) cfg_write(REG_SIZE_W, w);
        if ($urandom_range(99) < 15)
            cfg_write(CFG_IDX_BITS'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      SIZE_BITS'($urandom_range(0, 8191)));
        if (h != dim_h || $urandom_range(1)) cfg_write(REG_SIZE_H, h);
        if (c != dim_c || $urandom_range(1)) cfg_write(REG_SIZE_C, c);
        perm_data = pm;
        if ($urandom_range(99) < 25) perm_data[SIZE_BITS-1:3] = (SIZE_BITS-3)'($urandom);
        cfg_write(REG_PERM, perm_data);
        if (total == 0 || total > MAX_ELEMS) begin
            repeat ($urandom_range(2, 6)) begin
                idle_maybe();
                issue(1'($urandom_range(1)), $urandom);
            end
            return;
        end
        rounds = ($urandom_range(99) < 30) ? 2 : 1;
        repeat (rounds) begin
            early_at = ($urandom_range(99) < 10) ? $urandom_range(0, 32'(total - 1))
                                                 : 32'(total);
            for (k = 0; k < total; k++) begin
                if (k == early_at) begin
                    idle_maybe();
                    issue(OP_FETCH, $urandom);
                end
                idle_maybe();
                issue(OP_LOAD, $urandom);
            end
            if ($urandom_range(99) < 15) begin
                idle_maybe();
                issue(OP_LOAD, $urandom);
            end
            stop_at = ($urandom_range(99) < 8) ? $urandom_range(1, 32'(total)) : 32'(total);
            for (k = 0; k < stop_at; k++) begin
                idle_maybe();
                issue(OP_FETCH, $urandom);
            end
        end
    endtask

    function automatic t_row cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                     input logic [SIZE_BITS-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_index = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_row item_row(input logic op, input logic [WORD_BITS-1:0] word);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = op;
        r.word = word;
        return r;
    endfunction

    function automatic t_row item_chk(input logic op, input logic [WORD_BITS-1:0] word,
                                      input logic [WORD_BITS-1:0] rw, input logic rl,
                                      input logic [1:0] rs);
        t_row r;
        r = item_row(op, word);
        r.typed = 1'b1;
        r.want = '{word: rw, last: rl, status: rs};
        return r;
    endfunction

    initial begin : stimulus
        t_row plan [$];
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
        logic [SIZE_BITS-1:0] c;
        int unsigned pick;
        plan = '{
            item_chk(OP_FETCH, 32'h0000_0000, 32'h0, 1'b0, ST_EARLY),
            item_chk(OP_LOAD,  32'hFFFF_FFFF, 32'h0, 1'b0, ST_OK),
            item_chk(OP_LOAD,  32'h1234_5678, 32'h0, 1'b0, ST_BAD),
            item_chk(OP_FETCH, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b1, ST_OK),
            item_chk(OP_FETCH, 32'h0000_0000, 32'h0, 1'b0, ST_EARLY),
            item_chk(OP_LOAD,  32'h0000_0000, 32'h0, 1'b0, ST_OK),
            item_chk(OP_FETCH, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_OK),
            cfg_row(REG_SIZE_H, 13'd0),
            item_chk(OP_LOAD,  32'h0000_0001, 32'h0, 1'b0, ST_BAD),
            item_chk(OP_FETCH, 32'h0000_0000, 32'h0, 1'b0, ST_BAD),
            cfg_row(REG_SIZE_H, 13'd1),
            cfg_row(REG_SIZE_W, 13'd8191),
            item_chk(OP_LOAD,  32'h8000_0000, 32'h0, 1'b0, ST_BAD),
            cfg_row(REG_SIZE_W, 13'd4097),
            item_chk(OP_FETCH, 32'h7FFF_FFFF, 32'h0, 1'b0, ST_BAD),
            cfg_row(REG_SIZE_W, 13'd2),
            cfg_row(REG_SIZE_C, 13'd2),
            cfg_row(REG_PERM, {10'd0, PERM_WHC}),
            item_row(OP_LOAD, 32'h0000_00C0),
            item_row(OP_LOAD, 32'h0000_00C1),
            cfg_row(REG_UNUSED_FIRST, 13'd8191),
            item_row(OP_LOAD, 32'h0000_01C0),
            item_row(OP_LOAD, 32'h0000_01C1),
            cfg_row(REG_UNUSED_LAST, 13'd0),
            item_row(OP_FETCH, 32'h0),
            item_row(OP_FETCH, 32'h0),
            item_row(OP_FETCH, 32'h0),
            item_row(OP_FETCH, 32'h0),
            cfg_row(REG_PERM, {10'd0, PERM_SPARE_A}),
            item_chk(OP_FETCH, 32'h0, 32'h0, 1'b0, ST_EARLY),
            cfg_row(REG_PERM, {10'd0, PERM_SPARE_B}),
            item_chk(OP_LOAD, 32'h5A5A_5A5A, 32'h0, 1'b0, ST_OK)
        };
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_op = OP_LOAD;
        i_word_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SIZE_W;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                cfg_write(plan[i].cfg_index, plan[i].cfg_data);
            end else begin
                typed_on = plan[i].typed;
                typed_val = plan[i].want;
                issue(plan[i].op, plan[i].word);
                typed_on = 1'b0;
            end
        end

        while (n_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                w = SIZE_BITS'($urandom_range(1, 4));
                h = SIZE_BITS'($urandom_range(1, 4));
                c = SIZE_BITS'($urandom_range(1, 4));
                case ($urandom_range(0, 5))
                    0: w = '0;
                    1: h = '0;
                    2: c = '0;
                    3: begin w = 13'd64; h = 13'd64; c = 13'd2; end
                    4: begin w = 13'd8191; h = 13'd8191; c = 13'd8191; end
                    default: begin w = 13'd1; h = 13'd4097; c = 13'd1; end
                endcase
            end else if (pick < 20) begin
                w = SIZE_BITS'($urandom_range(1, 6));
                h = SIZE_BITS'($urandom_range(1, 6));
                c = SIZE_BITS'($urandom_range(1, 6));
            end else begin
                w = SIZE_BITS'($urandom_range(1, 4));
                h = SIZE_BITS'($urandom_range(1, 4));
                c = SIZE_BITS'($urandom_range(1, 4));
            end
            tensor_pass(w, h, c, 3'($urandom_range(PERM_CHW, PERM_SPARE_B)));
        end

        // full store along one axis is a legal size: loads pass, fetches come early
        drain();
        w = 13'd1;
        h = 13'd1;
        c = 13'd1;
        case ($urandom_range(0, 2))
            0:       w = 13'd4096;
            1:       h = 13'd4096;
            default: c = 13'd4096;
        endcase
        cfg_write(REG_SIZE_W, w);
        cfg_write(REG_SIZE_H, h);
        cfg_write(REG_SIZE_C, c);
        repeat (8) begin
            idle_maybe();
            issue(1'($urandom_range(1)), $urandom);
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("tensor_axis_permute_3d test passed");
        end else begin
            $display("tensor_axis_permute_3d test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tap_pkg.sv
rtl/tap_store.sv
rtl/tap_ctrl.sv
rtl/tensor_axis_permute_3d.sv
rtl/tap_check.sv
tb/tb.sv
